[rtl/qbc_pkg.sv]
// qbc_pkg: widths, constants, register indexes and coding codes for the
// quality bit compactor. No dependencies.
package qbc_pkg;

  localparam int QWORD_W      = 16;  // quality word and used-bit mask width
  localparam int PACK_W       = 8;   // packed quality byte width
  localparam int CODE_W       = 2;   // coding field width
  localparam int ACT_W        = 5;   // active_bits register width
  localparam int QUALITY_BITS = 16;  // limit on counted word bits
  localparam int GROUP_COUNT  = 6;   // grouped output bits in use
  localparam int MASK_REGS    = 6;   // group mask registers present
  localparam int GATHER_LIMIT = 8;   // most used bits that can be gathered
  localparam int HALF_W       = QWORD_W / 2;
  localparam int POS_W        = $clog2(QWORD_W) + 1;  // prefix count width

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PLAIN_COPY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRP_FIRST  = 3'd2;

  // Request types
  localparam logic REQ_SURVEY  = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Coding codes
  localparam logic [CODE_W-1:0] CODE_ZERO   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_GATHER = 2'd1;
  localparam logic [CODE_W-1:0] CODE_GROUP  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_PLAIN  = 2'd3;

  typedef logic [QWORD_W-1:0] qword_t;
  typedef logic [PACK_W-1:0]  pack_t;
  typedef qword_t grp_masks_t [MASK_REGS];

endpackage

[rtl/quality_bit_compactor_unit.sv]
// quality_bit_compactor_unit: top level of the quality bit compactor.
// Depends on qbc_pkg for widths, codes and register indexes.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle unless stalled: a survey word
//   (in_req_type = 0) ORs its low active bits into the used-bit mask, with
//   in_restart_survey clearing the mask first; a convert word (in_req_type = 1)
//   produces one result on the output channel (out_valid/out_ready).
//   Survey words produce no result.
//   Path: a convert word is held in the input register, then in the result
//   register until taken (one input register, one result register).
//   Throughput: one word per cycle when not stalled, set by the single compute
//   stage between the two registers.
//   Stall: while the result register holds an untaken word, a convert word in
//   the input register holds; survey words still drain. in_ready follows.
//   Reset (rst_n low, synchronous): both registers empty, used-bit mask zero,
//   plain_copy_mode 0, active_bits 16, group masks zero.
//   Configuration: APB-style port, register i at byte address 4*i; write only
//   while no word is in flight.
module quality_bit_compactor_unit
  import qbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic                  in_restart_survey,
  input  logic [QWORD_W-1:0]    in_quality_word,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PACK_W-1:0]     out_packed_quality,
  output logic [CODE_W-1:0]     out_coding_used,
  output logic                  out_unmatched_bits,
  output logic [QWORD_W-1:0]    out_used_bits,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             plain_mode_r;
  logic [ACT_W-1:0] active_bits_r;
  grp_masks_t       grp_mask_r;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_mode_r  <= 1'b0;
      active_bits_r <= ACT_W'(QWORD_W);
      for (int g = 0; g < MASK_REGS; g++) begin
        grp_mask_r[g] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_PLAIN_COPY) begin
        plain_mode_r <= cfg_pwdata[0];
      end else if (cfg_idx == REG_ACTIVE) begin
        active_bits_r <= cfg_pwdata[ACT_W-1:0];
      end
      for (int g = 0; g < MASK_REGS; g++) begin
        if (cfg_idx == REG_GRP_FIRST + REG_IDX_W'(g)) begin
          grp_mask_r[g] <= cfg_pwdata[QWORD_W-1:0];
        end
      end
    end
  end

  // Read back: decode the addressed register.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == REG_PLAIN_COPY) begin
      cfg_prdata[0] = plain_mode_r;
    end else if (cfg_idx == REG_ACTIVE) begin
      cfg_prdata[ACT_W-1:0] = active_bits_r;
    end
    for (int g = 0; g < MASK_REGS; g++) begin
      if (cfg_idx == REG_GRP_FIRST + REG_IDX_W'(g)) begin
        cfg_prdata[QWORD_W-1:0] = grp_mask_r[g];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic         a_valid_r;
  logic         a_req_r;
  logic         a_restart_r;
  qword_t       a_word_r;
  logic         a_advance;
  logic         in_take;
  logic         out_valid_r;

  // A survey word needs no result slot; a convert word needs a free or
  // draining result register.
  assign a_advance = a_valid_r &
                     ((a_req_r == REQ_SURVEY) | ~out_valid_r | out_ready);
  assign in_ready  = ~a_valid_r | a_advance;
  assign in_take   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_req_r     <= in_req_type;
      a_restart_r <= in_restart_survey;
      a_word_r    <= in_quality_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Used-bit mask (survey pass)
  // ---------------------------------------------------------------------------
  qword_t used_mask_r;
  qword_t used_mask_nxt;
  qword_t act_mask;

  // Bit i counts when i is below both active_bits and the word limit.
  always_comb begin
    for (int i = 0; i < QWORD_W; i++) begin
      act_mask[i] = (i < QUALITY_BITS) && (active_bits_r > ACT_W'(i));
    end
  end

  always_comb begin
    used_mask_nxt = used_mask_r;
    if (a_advance && (a_req_r == REQ_SURVEY)) begin
      used_mask_nxt = (a_restart_r ? '0 : used_mask_r) | (a_word_r & act_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_mask_r <= '0;
    end else begin
      used_mask_r <= used_mask_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Convert: gather, group or truncate
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos   [QWORD_W];  // output slot of each used bit
  logic [POS_W-1:0] lo_cnt;
  logic [POS_W-1:0] hi_cnt;
  logic [POS_W-1:0] nused;
  pack_t            gather_val;
  pack_t            group_val;
  pack_t            packed_nxt;
  logic [CODE_W-1:0] coding_nxt;
  logic             unmatched_nxt;

  // Prefix counts in two independent halves, upper half offset by the
  // lower half's total.
  always_comb begin
    lo_cnt = '0;
    hi_cnt = '0;
    for (int i = 0; i < HALF_W; i++) begin
      pos[i] = lo_cnt;
      lo_cnt = lo_cnt + POS_W'(used_mask_r[i]);
    end
    for (int i = 0; i < HALF_W; i++) begin
      pos[HALF_W+i] = hi_cnt;
      hi_cnt = hi_cnt + POS_W'(used_mask_r[HALF_W+i]);
    end
    for (int i = 0; i < HALF_W; i++) begin
      pos[HALF_W+i] = pos[HALF_W+i] + lo_cnt;
    end
    nused = lo_cnt + hi_cnt;
  end

  // Parallel bit extract: slot p takes the used bit whose prefix count is p.
  always_comb begin
    for (int p = 0; p < PACK_W; p++) begin
      gather_val[p] = 1'b0;
      for (int i = 0; i < QWORD_W; i++) begin
        if (used_mask_r[i] && a_word_r[i] && (pos[i] == POS_W'(p))) begin
          gather_val[p] = 1'b1;
        end
      end
    end
  end

  // Output bits past the group registers stay zero.
  always_comb begin
    group_val = '0;
    for (int g = 0; g < MASK_REGS; g++) begin
      if (g < GROUP_COUNT && g < PACK_W) begin
        group_val[g] = |(a_word_r & grp_mask_r[g]);
      end
    end
  end

  always_comb begin
    packed_nxt    = '0;
    coding_nxt    = CODE_ZERO;
    unmatched_nxt = 1'b0;
    if (plain_mode_r) begin
      packed_nxt = a_word_r[PACK_W-1:0];
      coding_nxt = CODE_PLAIN;
    end else if (nused == '0) begin
      coding_nxt = CODE_ZERO;
    end else if (nused <= POS_W'(GATHER_LIMIT)) begin
      packed_nxt = gather_val;
      coding_nxt = CODE_GATHER;
    end else begin
      packed_nxt    = group_val;
      coding_nxt    = CODE_GROUP;
      unmatched_nxt = (a_word_r != '0) && (group_val == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              load_out;
  pack_t             out_packed_r;
  logic [CODE_W-1:0] out_coding_r;
  logic              out_unmatched_r;
  qword_t            out_used_r;

  assign load_out = a_advance & (a_req_r == REQ_CONVERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the word until taken; load only when the slot frees.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_packed_r    <= packed_nxt;
      out_coding_r    <= coding_nxt;
      out_unmatched_r <= unmatched_nxt;
      out_used_r      <= used_mask_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_packed_quality = out_packed_r;
  assign out_coding_used    = out_coding_r;
  assign out_unmatched_bits = out_unmatched_r;
  assign out_used_bits      = out_used_r;

endmodule

[dv/quality_bit_compactor_unit_tb.sv]
`timescale 1ns / 1ps
// quality_bit_compactor_unit_tb: self-checking bench for the quality bit compactor.
// Streams survey and convert words with random idling on both channels and checks
// every result byte against a predictor. Depends on qbc_pkg and the compactor top.
module quality_bit_compactor_unit_tb;
  import qbc_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_CYCLES    = 4;
  localparam int STALL_LIMIT     = 1000;  // cycles with no handshake at all
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 130;
  localparam int MAX_REPORTS     = 100;

  // One input word and one result byte with its side fields.
  typedef struct packed {
    logic   req;
    logic   restart;
    qword_t word;
  } qitem_t;

  typedef struct packed {
    pack_t             pq;
    logic [CODE_W-1:0] code;
    logic              unmatched;
    qword_t            used;
  } qbyte_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic                  in_req_type       = REQ_SURVEY;
  logic                  in_restart_survey = 1'b0;
  logic [QWORD_W-1:0]    in_quality_word   = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [PACK_W-1:0]     out_packed_quality;
  logic [CODE_W-1:0]     out_coding_used;
  logic                  out_unmatched_bits;
  logic [QWORD_W-1:0]    out_used_bits;
  logic                  cfg_psel          = 1'b0;
  logic                  cfg_penable       = 1'b0;
  logic                  cfg_pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr         = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata        = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor copy of the registers and of the used-bit mask.
  logic             cfg_plain;
  logic [ACT_W-1:0] cfg_active;
  grp_masks_t       cfg_groups;
  qword_t           used_now;

  // Idling knobs, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  qitem_t words_to_drive[$];   // words not yet put on the wire
  qbyte_t expected_bytes[$];   // predicted bytes, oldest first
  qitem_t on_wire;             // word currently offered to the block
  int     words_unaccepted = 0;
  int     mismatches       = 0;
  int     idle_cycles      = 0;

  always #HALF_PERIOD clk = ~clk;

  quality_bit_compactor_unit dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Low word bits that a survey word may add to the used-bit mask. Zero counts
  // nothing; anything past the word width counts every bit.
  function automatic qword_t counted_bits_mask();
    logic [QWORD_W:0] wide;
    int               n;
    n    = (cfg_active > QUALITY_BITS) ? QUALITY_BITS : int'(cfg_active);
    wide = 1;
    wide = (wide << n) - 1'b1;
    return wide[QWORD_W-1:0];
  endfunction

  // Advance the used-bit mask on a survey word, or work out the byte for a
  // convert word. Returns 1 when the word produces a result.
  function automatic logic compact_word(input qitem_t it, output qbyte_t res);
    int pos;
    res = '0;
    if (it.req == REQ_SURVEY) begin
      if (it.restart) used_now = '0;
      used_now = used_now | (it.word & counted_bits_mask());
      return 1'b0;
    end
    // restart flag on a convert word has no effect
    if (cfg_plain) begin
      res.pq   = it.word[PACK_W-1:0];
      res.code = CODE_PLAIN;
    end else if ($countones(used_now) == 0) begin
      res.code = CODE_ZERO;
    end else if ($countones(used_now) <= GATHER_LIMIT) begin
      // pack the used positions down to the low byte, lowest first
      res.code = CODE_GATHER;
      pos      = 0;
      for (int b = 0; b < QWORD_W; b++) begin
        if (used_now[b]) begin
          if (it.word[b] && pos < PACK_W) res.pq[pos] = 1'b1;
          pos++;
        end
      end
    end else begin
      // one output bit per group the word touches
      res.code = CODE_GROUP;
      for (int g = 0; g < GROUP_COUNT && g < PACK_W; g++) begin
        if ((it.word & cfg_groups[g]) != '0) res.pq[g] = 1'b1;
      end
      res.unmatched = (it.word != '0) && (res.pq == '0);
    end
    res.used = used_now;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued words, predict on every accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    qbyte_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (compact_word(on_wire, res)) expected_bytes.push_back(res);
        words_unaccepted--;
      end
      // hold the word until taken; only then pick the next or go idle
      if (!in_valid || in_ready) begin
        if (words_to_drive.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire           = words_to_drive.pop_front();
          in_valid          <= 1'b1;
          in_req_type       <= on_wire.req;
          in_restart_survey <= on_wire.restart;
          in_quality_word   <= on_wire.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input qword_t want, input qword_t got);
    mismatches++;
    // keep the log short once things are clearly broken
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : check_bytes
    qbyte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with none expected: expected nothing actual %h/%0d",
                     $time, out_packed_quality, out_coding_used);
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_quality !== want.pq)
            note_mismatch("packed_quality", qword_t'(want.pq), qword_t'(out_packed_quality));
          if (out_coding_used !== want.code)
            note_mismatch("coding_used", qword_t'(want.code), qword_t'(out_coding_used));
          if (out_unmatched_bits !== want.unmatched)
            note_mismatch("unmatched_bits", qword_t'(want.unmatched),
                          qword_t'(out_unmatched_bits));
          if (out_used_bits !== want.used)
            note_mismatch("used_bits", want.used, out_used_bits);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write every register and track it in the predictor.
  task automatic set_config(input logic plain, input logic [ACT_W-1:0] act,
                            input grp_masks_t groups);
    write_reg(REG_PLAIN_COPY, CFG_DATA_W'(plain));
    cfg_plain = plain;
    write_reg(REG_ACTIVE, CFG_DATA_W'(act));
    cfg_active = act;
    for (int g = 0; g < MASK_REGS; g++) begin
      write_reg(REG_GRP_FIRST + REG_IDX_W'(g), CFG_DATA_W'(groups[g]));
      cfg_groups[g] = groups[g];
    end
  endtask

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 27 : 0;
    stall_pct     = (mode == 2) ? 45 : (mode == 3) ? 27 : 0;
  endtask

  task automatic push_word(input logic req, input logic restart, input qword_t word);
    qitem_t it;
    it.req     = req;
    it.restart = restart;
    it.word    = word;
    words_to_drive.push_back(it);
    words_unaccepted++;
  endtask

  // Wait until every word is taken and every result is back, then let any
  // trailing survey word clear the pipeline.
  task automatic drain_words();
    @(posedge clk);
    while (words_unaccepted != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic qword_t sparse_word();
    qword_t w;
    w = '0;
    w[$urandom_range(QWORD_W-1)] = 1'b1;
    if ($urandom_range(1) == 1) w[$urandom_range(QWORD_W-1)] = 1'b1;
    return w;
  endfunction

  // Mostly one or two bits so the used count lands on both sides of eight.
  function automatic qword_t survey_word();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return sparse_word();
    if (pick < 9) return qword_t'($urandom);
    return ($urandom_range(1) == 1) ? '1 : '0;
  endfunction

  function automatic qword_t convert_word();
    qword_t hit_any;
    int     pick;
    hit_any = '0;
    for (int g = 0; g < GROUP_COUNT; g++) hit_any = hit_any | cfg_groups[g];
    pick = $urandom_range(9);
    case (pick)
      0: return '0;
      1: return '1;
      2: return sparse_word();
      3: return qword_t'($urandom) & ~hit_any;   // misses every group
      default: return qword_t'($urandom);
    endcase
  endfunction

  // Mostly a survey run opened by a restart followed by a convert run; the
  // rest is loose words of either kind.
  task automatic random_words(input int count);
    int sent;
    int runs;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        runs = $urandom_range(1, 6);
        for (int k = 0; k < runs; k++)
          push_word(REQ_SURVEY, (k == 0) || ($urandom_range(15) == 0), survey_word());
        sent += runs;
        runs = $urandom_range(1, 10);
        for (int k = 0; k < runs; k++)
          push_word(REQ_CONVERT, $urandom_range(1) == 1, convert_word());
        sent += runs;
      end else begin
        push_word($urandom_range(1) == 1, $urandom_range(1) == 1, qword_t'($urandom));
        sent++;
      end
    end
  endtask

  // Early phases hit the extremes of active_bits and the group masks.
  task automatic random_config(input int phase);
    grp_masks_t       groups;
    logic [ACT_W-1:0] act;
    for (int g = 0; g < MASK_REGS; g++) begin
      case ($urandom_range(5))
        0: groups[g] = '0;
        1: groups[g] = '1;
        2, 3: groups[g] = qword_t'($urandom) & qword_t'($urandom);
        default: groups[g] = qword_t'($urandom);
      endcase
      if (phase == 5) groups[g] = '0;
      if (phase == 6) groups[g] = '1;
    end
    case (phase)
      0: act = '0;
      1: act = ACT_W'(1);
      2: act = ACT_W'(QUALITY_BITS);
      3: act = ACT_W'(QUALITY_BITS + 1);
      4: act = '1;
      default: act = ($urandom_range(1) == 1) ? ACT_W'(QUALITY_BITS)
                                               : ACT_W'($urandom_range(31));
    endcase
    set_config(phase % 5 == 2, act, groups);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    grp_masks_t groups;
    cfg_plain  = 1'b0;
    cfg_active = ACT_W'(16);
    cfg_groups = '{default: '0};
    used_now   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Gather, grouping and the empty mask with six disjoint groups; bit 15
    // belongs to no group.
    groups = '{16'h0003, 16'h000C, 16'h0030, 16'h00C0, 16'h0F00, 16'h7000};
    set_config(1'b0, ACT_W'(16), groups);
    set_idling(0);
    push_word(REQ_CONVERT, 1'b1, 16'hFFFF);   // empty mask; restart ignored
    push_word(REQ_SURVEY,  1'b1, 16'h0000);
    push_word(REQ_SURVEY,  1'b0, 16'h8001);   // two used bits
    push_word(REQ_CONVERT, 1'b0, 16'hFFFF);
    push_word(REQ_CONVERT, 1'b0, 16'h8000);
    push_word(REQ_SURVEY,  1'b0, 16'h00FC);   // exactly eight used bits
    push_word(REQ_CONVERT, 1'b1, 16'hAAAA);
    push_word(REQ_CONVERT, 1'b0, 16'hFFFF);
    push_word(REQ_SURVEY,  1'b0, 16'h0200);   // nine: grouped from here
    push_word(REQ_CONVERT, 1'b0, 16'h8000);   // hits no group
    push_word(REQ_CONVERT, 1'b0, 16'h0000);
    push_word(REQ_CONVERT, 1'b0, 16'hFFFF);
    push_word(REQ_SURVEY,  1'b1, 16'hFFFF);
    push_word(REQ_CONVERT, 1'b0, 16'h0001);
    drain_words();

    // Plain truncation; the survey still narrows the mask to three bits.
    set_config(1'b1, ACT_W'(3), groups);
    set_idling(3);
    push_word(REQ_SURVEY,  1'b1, 16'h00FF);
    push_word(REQ_CONVERT, 1'b0, 16'hABCD);
    push_word(REQ_CONVERT, 1'b1, 16'h0000);
    drain_words();

    // No bits counted at all.
    set_config(1'b0, ACT_W'(0), groups);
    push_word(REQ_SURVEY,  1'b1, 16'hFFFF);
    push_word(REQ_CONVERT, 1'b0, 16'h1234);
    drain_words();

    // Active count past the word width counts every bit.
    set_config(1'b0, '1, groups);
    push_word(REQ_SURVEY,  1'b1, 16'hFFFF);
    push_word(REQ_CONVERT, 1'b0, 16'h8000);
    push_word(REQ_CONVERT, 1'b0, 16'h00FF);
    drain_words();

    // Single counted bit.
    set_config(1'b0, ACT_W'(1), groups);
    push_word(REQ_SURVEY,  1'b1, 16'hFFFF);
    push_word(REQ_CONVERT, 1'b0, 16'hFFFF);
    drain_words();

    // Random phases, each under a fresh configuration and idling pattern.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_config(phase);
      set_idling(phase % 4);
      random_words(WORDS_PER_PHASE);
      drain_words();
    end

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
